// ===== rtl/rsdf_pkg.sv =====
// Shared types, constants and register codes of the range sensor difference filter.
package rsdf_pkg;

  localparam int RANGE_W    = 16;
  localparam int GOAL_W     = 15;
  localparam int DIFF_W     = 16;
  localparam int NUM_SNS    = 4;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam int SNS_FRONT = 0;
  localparam int SNS_BACK  = 1;
  localparam int SNS_LEFT  = 2;
  localparam int SNS_RIGHT = 3;

  localparam int HISTORY_DEPTH_DEF = 2;
  localparam int DIFF_WINDOW_DEF   = 4;
  localparam int MID_DEPTH         = 2;
  localparam int OUT_DEPTH         = 8;

  localparam logic [RANGE_W-1:0] MIN_DIST_RST  = '0;
  localparam logic [RANGE_W-1:0] MAX_DIST_RST  = '1;
  localparam logic [GOAL_W-1:0]  GOAL_DIST_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MIN_DIST  = 2'd0,
    CFG_MAX_DIST  = 2'd1,
    CFG_GOAL_DIST = 2'd2
  } rsdf_cfg_e;

  typedef struct packed {
    logic [RANGE_W-1:0] front_range;
    logic [RANGE_W-1:0] back_range;
    logic [RANGE_W-1:0] left_range;
    logic [RANGE_W-1:0] right_range;
  } rsdf_in_t;

  typedef struct packed {
    logic signed [DIFF_W-1:0] x_offset;
    logic signed [DIFF_W-1:0] y_offset;
  } rsdf_out_t;

endpackage

// ===== rtl/rsdf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rsdf_ram #(
  parameter int W     = 32,
  parameter int DEPTH = 4,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/rsdf_fifo.sv =====
// Small register FIFO with occupancy count.
module rsdf_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2,
  localparam int CW   = $clog2(DEPTH + 1)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  logic [W-1:0]  data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic [W-1:0]  data_o,
  output logic          empty_o,
  output logic [CW-1:0] count_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;
  assign data_o  = mem_q[rd_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q + CW'(do_push) - CW'(do_pop);
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= data_i;
    end
  end

endmodule

// ===== rtl/rsdf_front.sv =====
// Front end: clamps each reading, shifts it into the per-sensor history, keeps running sums.
module rsdf_front #(
  parameter int HD     = 2,
  localparam int SUM_W = rsdf_pkg::RANGE_W + $clog2(HD)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               acc_i,
  input  rsdf_pkg::rsdf_in_t                 in_i,
  input  logic [rsdf_pkg::RANGE_W-1:0]       min_dist_i,
  input  logic [rsdf_pkg::RANGE_W-1:0]       max_dist_i,
  output logic [rsdf_pkg::NUM_SNS*SUM_W-1:0] sums_o
);

  import rsdf_pkg::*;

  localparam logic [SUM_W-1:0] SUM_RST = SUM_W'(HD * ((1 << RANGE_W) - 1));

  logic [RANGE_W-1:0] raw     [NUM_SNS];
  logic [RANGE_W-1:0] clamped [NUM_SNS];
  logic [RANGE_W-1:0] hist_q  [NUM_SNS][HD];
  logic [SUM_W-1:0]   sum_q   [NUM_SNS];
  logic [SUM_W-1:0]   sum_d   [NUM_SNS];

  assign raw[SNS_FRONT] = in_i.front_range;
  assign raw[SNS_BACK]  = in_i.back_range;
  assign raw[SNS_LEFT]  = in_i.left_range;
  assign raw[SNS_RIGHT] = in_i.right_range;

  // Running sum: add the new reading, drop the one that falls off the end.
  always_comb begin
    for (int s = 0; s < NUM_SNS; s++) begin
      if (raw[s] < min_dist_i) begin
        clamped[s] = min_dist_i;
      end else if (raw[s] > max_dist_i) begin
        clamped[s] = max_dist_i;
      end else begin
        clamped[s] = raw[s];
      end
      sum_d[s] = sum_q[s] - SUM_W'(hist_q[s][HD-1]) + SUM_W'(clamped[s]);
      sums_o[s*SUM_W +: SUM_W] = sum_d[s];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SNS; s++) begin
        sum_q[s] <= SUM_RST;
        for (int i = 0; i < HD; i++) begin
          hist_q[s][i] <= '1;
        end
      end
    end else if (acc_i) begin
      for (int s = 0; s < NUM_SNS; s++) begin
        sum_q[s]     <= sum_d[s];
        hist_q[s][0] <= clamped[s];
        for (int i = 1; i < HD; i++) begin
          hist_q[s][i] <= hist_q[s][i-1];
        end
      end
    end
  end

endmodule

// ===== rtl/rsdf_back.sv =====
// Back end: history means, goal clamp and differences, difference window, window means.
module rsdf_back #(
  parameter int HD        = 2,
  parameter int DW        = 4,
  parameter int OUT_DEPTH = 8,
  localparam int SUM_W    = rsdf_pkg::RANGE_W + $clog2(HD),
  localparam int OCW      = $clog2(OUT_DEPTH + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [rsdf_pkg::NUM_SNS*SUM_W-1:0] mid_data_i,
  input  logic                               mid_empty_i,
  output logic                               mid_pop_o,
  input  logic [OCW-1:0]                     out_count_i,
  input  logic [rsdf_pkg::GOAL_W-1:0]        goal_dist_i,
  output logic                               res_push_o,
  output rsdf_pkg::rsdf_out_t                res_o
);

  import rsdf_pkg::*;

  localparam int NAX = 2;
  localparam int AX_X = 0;
  localparam int AX_Y = 1;

  // History mean by reciprocal multiply, exact for any sum below 2^SUM_W.
  localparam int HL   = $clog2(HD);
  localparam int HS   = SUM_W + HL;
  localparam int HM_W = SUM_W + 1;
  localparam logic [HM_W-1:0] HM = HM_W'(((64'd1 << HS) + 64'(HD) - 64'd1) / 64'(HD));
  localparam int HP_W = SUM_W + HM_W;

  // Window mean on the magnitude, exact for any magnitude below 2^MAG_W.
  localparam int WL    = $clog2(DW);
  localparam int MAG_W = DIFF_W - 1 + WL;
  localparam int WS_W  = MAG_W + 1;
  localparam int WSH   = MAG_W + WL;
  localparam int WM_W  = MAG_W + 1;
  localparam logic [WM_W-1:0] WM = WM_W'(((64'd1 << WSH) + 64'(DW) - 64'd1) / 64'(DW));
  localparam int WP_W  = MAG_W + WM_W;

  localparam int PW = (DW > 1) ? $clog2(DW) : 1;
  localparam int EW = 2 * DIFF_W;
  localparam int TW = OCW + 3;

  // ---- issue ----
  logic          s1_vld_q, s2_vld_q, s3_vld_q, s4_vld_q, s5_vld_q;
  logic [PW-1:0] ptr_q;
  logic          wrapped_q;
  logic [TW-1:0] in_flight;
  logic          fwd;

  assign in_flight = TW'(s1_vld_q) + TW'(s2_vld_q) + TW'(s3_vld_q)
                   + TW'(s4_vld_q) + TW'(s5_vld_q);
  // Only issue when the result queue has room for everything in flight.
  assign mid_pop_o = !mid_empty_i && ((TW'(out_count_i) + in_flight) < TW'(OUT_DEPTH));

  logic [HP_W-1:0] s1_prod_q [NUM_SNS];
  logic [PW-1:0]   s1_ptr_q;
  logic            s1_ovld_q;
  logic            s1_fwd_q;
  logic [EW-1:0]   s1_fwd_data_q;

  // ---- stage 1: means, clamp, differences, window write ----
  logic [RANGE_W-1:0]      avg [NUM_SNS];
  logic [GOAL_W-1:0]       cl  [NUM_SNS];
  logic signed [DIFF_W-1:0] dx, dy;
  logic [EW-1:0]           wdata, rdata, old;

  always_comb begin
    for (int s = 0; s < NUM_SNS; s++) begin
      avg[s] = s1_prod_q[s][HS +: RANGE_W];
      cl[s]  = (avg[s] > {1'b0, goal_dist_i}) ? goal_dist_i : avg[s][GOAL_W-1:0];
    end
  end

  assign dx    = $signed({1'b0, cl[SNS_BACK]}) - $signed({1'b0, cl[SNS_FRONT]});
  assign dy    = $signed({1'b0, cl[SNS_RIGHT]}) - $signed({1'b0, cl[SNS_LEFT]});
  assign wdata = {dx, dy};

  // Stage 1 writes the slot being read: the RAM read returns stale data.
  assign fwd = s1_vld_q && (s1_ptr_q == ptr_q);

  always_comb begin
    if (s1_fwd_q) begin
      old = s1_fwd_data_q;
    end else if (s1_ovld_q) begin
      old = rdata;
    end else begin
      old = '0;
    end
  end

  rsdf_ram #(
    .W    (EW),
    .DEPTH(DW)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (s1_vld_q),
    .waddr_i(s1_ptr_q),
    .wdata_i(wdata),
    .raddr_i(ptr_q),
    .rdata_o(rdata)
  );

  // ---- stage 2: running window sums ----
  logic signed [DIFF_W-1:0] s2_new_q [NAX];
  logic signed [DIFF_W-1:0] s2_old_q [NAX];
  logic signed [WS_W-1:0]   wsum_q   [NAX];
  logic signed [WS_W-1:0]   wsum_d   [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      wsum_d[a] = wsum_q[a] + WS_W'(s2_new_q[a]) - WS_W'(s2_old_q[a]);
    end
  end

  // ---- stage 3: sign and magnitude ----
  logic signed [WS_W-1:0] s3_sum_q [NAX];
  logic [MAG_W-1:0]       mag      [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      mag[a] = s3_sum_q[a][WS_W-1] ? MAG_W'(-s3_sum_q[a]) : MAG_W'(s3_sum_q[a]);
    end
  end

  // ---- stage 4: reciprocal multiply ----
  logic             s4_neg_q [NAX];
  logic [MAG_W-1:0] s4_mag_q [NAX];

  // ---- stage 5: quotient and sign restore ----
  logic              s5_neg_q  [NAX];
  logic [WP_W-1:0]   s5_prod_q [NAX];
  logic [DIFF_W-1:0] qmag      [NAX];
  logic [DIFF_W-1:0] res       [NAX];

  always_comb begin
    for (int a = 0; a < NAX; a++) begin
      qmag[a] = {1'b0, s5_prod_q[a][WSH +: DIFF_W-1]};
      res[a]  = s5_neg_q[a] ? (~qmag[a] + 1'b1) : qmag[a];
    end
  end

  assign res_push_o     = s5_vld_q;
  assign res_o.x_offset = res[AX_X];
  assign res_o.y_offset = res[AX_Y];

  // ---- control state ----
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      s2_vld_q  <= 1'b0;
      s3_vld_q  <= 1'b0;
      s4_vld_q  <= 1'b0;
      s5_vld_q  <= 1'b0;
      ptr_q     <= '0;
      wrapped_q <= 1'b0;
      for (int a = 0; a < NAX; a++) begin
        wsum_q[a] <= '0;
      end
    end else begin
      s1_vld_q <= mid_pop_o;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
      s4_vld_q <= s3_vld_q;
      s5_vld_q <= s4_vld_q;
      if (mid_pop_o) begin
        if (ptr_q == PW'(DW - 1)) begin
          ptr_q     <= '0;
          wrapped_q <= 1'b1;
        end else begin
          ptr_q <= ptr_q + 1'b1;
        end
      end
      if (s2_vld_q) begin
        for (int a = 0; a < NAX; a++) begin
          wsum_q[a] <= wsum_d[a];
        end
      end
    end
  end

  // ---- payload ----
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < NUM_SNS; s++) begin
      s1_prod_q[s] <= {{HM_W{1'b0}}, mid_data_i[s*SUM_W +: SUM_W]} * {{SUM_W{1'b0}}, HM};
    end
    s1_ptr_q      <= ptr_q;
    s1_ovld_q     <= wrapped_q;
    s1_fwd_q      <= fwd;
    s1_fwd_data_q <= wdata;

    s2_new_q[AX_X] <= dx;
    s2_new_q[AX_Y] <= dy;
    s2_old_q[AX_X] <= old[EW-1:DIFF_W];
    s2_old_q[AX_Y] <= old[DIFF_W-1:0];

    for (int a = 0; a < NAX; a++) begin
      s3_sum_q[a]  <= wsum_d[a];
      s4_neg_q[a]  <= s3_sum_q[a][WS_W-1];
      s4_mag_q[a]  <= mag[a];
      s5_neg_q[a]  <= s4_neg_q[a];
      s5_prod_q[a] <= {{WM_W{1'b0}}, s4_mag_q[a]} * {{MAG_W{1'b0}}, WM};
    end
  end

endmodule

// ===== rtl/range_sensor_diff_filter_core.sv =====
// Top level of the range sensor difference filter: config registers, front, queues, back.
//
//   channel   direction  handshake         payload
//   input     in         push_i / full_o   in_i  (front, back, left, right range)
//   result    out        pop_i / empty_o   out_o (x_offset, y_offset)
//   config    in         cfg_we_i          cfg_idx_i, cfg_wdata_i
//
// One item per cycle sustained while the result side keeps popping; a result passes the
// front, the middle queue, the issue step and five back stages on its way to the output queue.
// The back end issues only while the 8-entry result queue has room for every item in
// flight, so a stalled consumer backs up into the 2-entry middle queue and then full_o.
// Reset takes effect at once; no clearing pass, the window RAM is masked until first wrap.
module range_sensor_diff_filter_core #(
  parameter int HISTORY_DEPTH = rsdf_pkg::HISTORY_DEPTH_DEF,
  parameter int DIFF_WINDOW   = rsdf_pkg::DIFF_WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push_i,
  output logic                              full_o,
  input  rsdf_pkg::rsdf_in_t                in_i,
  output logic                              empty_o,
  input  logic                              pop_i,
  output rsdf_pkg::rsdf_out_t               out_o,
  input  logic                              cfg_we_i,
  input  logic [rsdf_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [rsdf_pkg::CFG_DATA_W-1:0]   cfg_wdata_i
);

  import rsdf_pkg::*;

  localparam int SUM_W = RANGE_W + $clog2(HISTORY_DEPTH);
  localparam int MID_W = NUM_SNS * SUM_W;
  localparam int OUT_W = $bits(rsdf_out_t);
  localparam int OCW   = $clog2(OUT_DEPTH + 1);

  logic [RANGE_W-1:0] min_dist_q, max_dist_q;
  logic [GOAL_W-1:0]  goal_dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_dist_q  <= MIN_DIST_RST;
      max_dist_q  <= MAX_DIST_RST;
      goal_dist_q <= GOAL_DIST_RST;
    end else if (cfg_we_i) begin
      case (rsdf_cfg_e'(cfg_idx_i))
        CFG_MIN_DIST:  min_dist_q  <= cfg_wdata_i[RANGE_W-1:0];
        CFG_MAX_DIST:  max_dist_q  <= cfg_wdata_i[RANGE_W-1:0];
        CFG_GOAL_DIST: goal_dist_q <= cfg_wdata_i[GOAL_W-1:0];
        default: ;
      endcase
    end
  end

  logic             in_acc;
  logic [MID_W-1:0] front_sums, mid_data;
  logic             mid_empty, mid_pop;
  logic [OCW-1:0]   out_count;
  logic             res_push;
  rsdf_out_t        res;
  logic [OUT_W-1:0] out_data;
  logic             out_full;
  logic [$clog2(MID_DEPTH+1)-1:0] mid_count;

  assign in_acc = push_i && !full_o;

  rsdf_front #(
    .HD(HISTORY_DEPTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .acc_i     (in_acc),
    .in_i      (in_i),
    .min_dist_i(min_dist_q),
    .max_dist_i(max_dist_q),
    .sums_o    (front_sums)
  );

  rsdf_fifo #(
    .W    (MID_W),
    .DEPTH(MID_DEPTH)
  ) u_mid_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (in_acc),
    .data_i (front_sums),
    .full_o (full_o),
    .pop_i  (mid_pop),
    .data_o (mid_data),
    .empty_o(mid_empty),
    .count_o(mid_count)
  );

  rsdf_back #(
    .HD       (HISTORY_DEPTH),
    .DW       (DIFF_WINDOW),
    .OUT_DEPTH(OUT_DEPTH)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .mid_data_i (mid_data),
    .mid_empty_i(mid_empty || (mid_count == '0)),
    .mid_pop_o  (mid_pop),
    .out_count_i(out_count),
    .goal_dist_i(goal_dist_q),
    .res_push_o (res_push),
    .res_o      (res)
  );

  rsdf_fifo #(
    .W    (OUT_W),
    .DEPTH(OUT_DEPTH)
  ) u_out_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push && !out_full),
    .data_i (res),
    .full_o (out_full),
    .pop_i  (pop_i),
    .data_o (out_data),
    .empty_o(empty_o),
    .count_o(out_count)
  );

  assign out_o = rsdf_out_t'(out_data);

endmodule

// ===== rtl/rsdf_checker.sv =====
// Port-level checks on the filter core, bound to the top level.
module rsdf_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                push_i,
  input logic                full_o,
  input logic                empty_o,
  input logic                pop_i,
  input rsdf_pkg::rsdf_out_t out_o
);

  // Both queues come out of reset empty.
  a_reset_state: assert property (@(posedge clk_i) $rose(rst_ni) |-> empty_o && !full_o)
    else $error("queues not empty after reset");

  // Input side fills only through an accepted beat.
  a_full_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(full_o) |-> $past(push_i && !full_o))
    else $error("full_o rose without an input beat");

  // Result side drains only through an accepted beat.
  a_empty_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(empty_o) |-> $past(pop_i && !empty_o))
    else $error("empty_o rose without a result beat");

  // A waiting result holds until taken.
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty_o && !pop_i |=> !empty_o && $stable(out_o))
    else $error("waiting result changed or vanished");

endmodule

bind range_sensor_diff_filter_core rsdf_checker u_rsdf_checker (.*);

// ===== dv/tb.sv =====
// Self-checking testbench of the range sensor difference filter core.

class offset_scoreboard;
  int unsigned min_dist;
  int unsigned max_dist;
  int unsigned goal_dist;
  logic [rsdf_pkg::RANGE_W-1:0] history [rsdf_pkg::NUM_SNS][rsdf_pkg::HISTORY_DEPTH_DEF];
  int diff_win [2][rsdf_pkg::DIFF_WINDOW_DEF];
  int wr_ptr;
  rsdf_pkg::rsdf_out_t expected_offsets [$];
  int errors;

  function new();
    min_dist  = 32'(rsdf_pkg::MIN_DIST_RST);
    max_dist  = 32'(rsdf_pkg::MAX_DIST_RST);
    goal_dist = 32'(rsdf_pkg::GOAL_DIST_RST);
    foreach (history[s, i]) history[s][i] = '1;
    foreach (diff_win[a, i]) diff_win[a][i] = 0;
    wr_ptr = 0;
    errors = 0;
  endfunction

  function void write_reg(logic [rsdf_pkg::CFG_IDX_W-1:0] idx,
                          logic [rsdf_pkg::CFG_DATA_W-1:0] data);
    case (idx)
      rsdf_pkg::CFG_MIN_DIST:  min_dist  = 32'(data);
      rsdf_pkg::CFG_MAX_DIST:  max_dist  = 32'(data);
      rsdf_pkg::CFG_GOAL_DIST: goal_dist = 32'(data[rsdf_pkg::GOAL_W-1:0]);
      default: ;
    endcase
  endfunction

  function int window_mean(int axis);
    int sum;
    sum = 0;
    for (int i = 0; i < rsdf_pkg::DIFF_WINDOW_DEF; i++) sum += diff_win[axis][i];
    // signed int division truncates toward zero
    return sum / rsdf_pkg::DIFF_WINDOW_DEF;
  endfunction

  function void predict_offsets(rsdf_pkg::rsdf_in_t beat);
    int unsigned raw [rsdf_pkg::NUM_SNS];
    int unsigned avg [rsdf_pkg::NUM_SNS];
    int unsigned v;
    int unsigned sum;
    rsdf_pkg::rsdf_out_t want;
    raw[rsdf_pkg::SNS_FRONT] = 32'(beat.front_range);
    raw[rsdf_pkg::SNS_BACK]  = 32'(beat.back_range);
    raw[rsdf_pkg::SNS_LEFT]  = 32'(beat.left_range);
    raw[rsdf_pkg::SNS_RIGHT] = 32'(beat.right_range);
    for (int s = 0; s < rsdf_pkg::NUM_SNS; s++) begin
      // inverted window: anything not below min ends up at max
      v = raw[s];
      if (v < min_dist) v = min_dist;
      else if (v > max_dist) v = max_dist;
      for (int i = rsdf_pkg::HISTORY_DEPTH_DEF - 1; i > 0; i--) history[s][i] = history[s][i-1];
      history[s][0] = v[rsdf_pkg::RANGE_W-1:0];
    end
    for (int s = 0; s < rsdf_pkg::NUM_SNS; s++) begin
      sum = 0;
      for (int i = 0; i < rsdf_pkg::HISTORY_DEPTH_DEF; i++) sum += 32'(history[s][i]);
      avg[s] = sum / rsdf_pkg::HISTORY_DEPTH_DEF;
      if (avg[s] > goal_dist) avg[s] = goal_dist;
    end
    diff_win[0][wr_ptr] = int'(avg[rsdf_pkg::SNS_BACK]) - int'(avg[rsdf_pkg::SNS_FRONT]);
    diff_win[1][wr_ptr] = int'(avg[rsdf_pkg::SNS_RIGHT]) - int'(avg[rsdf_pkg::SNS_LEFT]);
    wr_ptr = (wr_ptr + 1) % rsdf_pkg::DIFF_WINDOW_DEF;
    want.x_offset = 16'(window_mean(0));
    want.y_offset = 16'(window_mean(1));
    expected_offsets.push_back(want);
  endfunction

  function void check_offsets(rsdf_pkg::rsdf_out_t got);
    rsdf_pkg::rsdf_out_t want;
    if (expected_offsets.size() == 0) begin
      errors++;
      $display("%0t: unexpected result beat x_offset %0d y_offset %0d",
               $time, got.x_offset, got.y_offset);
      return;
    end
    want = expected_offsets.pop_front();
    if (got.x_offset !== want.x_offset) begin
      errors++;
      $display("%0t: x_offset expected %0d actual %0d", $time, want.x_offset, got.x_offset);
    end
    if (got.y_offset !== want.y_offset) begin
      errors++;
      $display("%0t: y_offset expected %0d actual %0d", $time, want.y_offset, got.y_offset);
    end
  endfunction

  function int pending();
    return expected_offsets.size();
  endfunction
endclass

module tb;
  import rsdf_pkg::*;

  localparam int LIMIT_CYCLES = 100000;
  localparam int HOLD_CYCLES  = 120;
  localparam int PHASE_BEATS  = 200;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  push_i      = 1'b0;
  logic                  pop_i       = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  rsdf_in_t              in_i        = '0;
  logic                  full_o;
  logic                  empty_o;
  rsdf_out_t             out_o;

  offset_scoreboard sb;
  int  tx_idle_pct = 25;
  int  rx_idle_pct = 50;
  logic hold_req   = 1'b0;
  int  hold_left   = 0;
  int  cycle_cnt   = 0;

  range_sensor_diff_filter_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .in_i        (in_i),
    .empty_o     (empty_o),
    .pop_i       (pop_i),
    .out_o       (out_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #5 clk_i = ~clk_i;

  // beat monitor: values sampled at the edge are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (push_i && !full_o) sb.predict_offsets(in_i);
      if (pop_i && !empty_o) sb.check_offsets(out_o);
    end
  end

  // result side: random pop, or a long hold-off when asked
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_req  <= 1'b0;
      hold_left <= HOLD_CYCLES;
      pop_i     <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      pop_i     <= 1'b0;
    end else begin
      pop_i <= ($urandom_range(99, 0) >= rx_idle_pct);
    end
  end

  initial begin
    while (cycle_cnt < LIMIT_CYCLES) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("range_sensor_diff_filter_core regression: fail");
    $finish;
  end

  function automatic rsdf_in_t ranges(logic [RANGE_W-1:0] f, logic [RANGE_W-1:0] b,
                                      logic [RANGE_W-1:0] l, logic [RANGE_W-1:0] r);
    rsdf_in_t beat;
    beat.front_range = f;
    beat.back_range  = b;
    beat.left_range  = l;
    beat.right_range = r;
    return beat;
  endfunction

  // bias readings toward the clamp and goal edges
  function automatic logic [RANGE_W-1:0] pick_range();
    int sel;
    int jitter;
    sel    = $urandom_range(99, 0);
    jitter = int'($urandom_range(8, 0)) - 4;
    if (sel < 45) return RANGE_W'($urandom);
    else if (sel < 60) return RANGE_W'(sb.min_dist + jitter);
    else if (sel < 75) return RANGE_W'(sb.max_dist + jitter);
    else if (sel < 90) return RANGE_W'(sb.goal_dist + jitter);
    else if (sel[0]) return '1;
    else return '0;
  endfunction

  task automatic push_beat(rsdf_in_t beat);
    while ($urandom_range(99, 0) < tx_idle_pct) begin
      push_i <= 1'b0;
      in_i   <= rsdf_in_t'({$urandom, $urandom});
      @(posedge clk_i);
    end
    push_i <= 1'b1;
    in_i   <= beat;
    do @(posedge clk_i); while (full_o);
  endtask

  task automatic drain_offsets();
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  task automatic set_config(logic [CFG_DATA_W-1:0] lo, logic [CFG_DATA_W-1:0] hi,
                            logic [CFG_DATA_W-1:0] goal);
    cfg_write(CFG_MIN_DIST, lo);
    cfg_write(CFG_MAX_DIST, hi);
    cfg_write(CFG_GOAL_DIST, goal);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] a;
    logic [CFG_DATA_W-1:0] b;
    sb = new();
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // start-up: history still full of all-ones entries
    push_beat(ranges('0, '0, '0, '0));
    push_beat(ranges('1, '1, '1, '1));
    repeat (4) push_beat(ranges('0, '1, '1, '0));
    repeat (4) push_beat(ranges('1, '0, '0, '1));
    push_i <= 1'b0;
    drain_offsets();

    // narrow window; goal written with bit 15 set
    set_config(16'd1000, 16'd60000, 16'hC000);
    push_beat(ranges(16'd999, 16'd1000, 16'd60000, 16'd60001));
    push_beat(ranges(16'd60001, 16'd999, 16'd1000, 16'd60000));
    push_beat(ranges(16'd1, 16'd2, 16'd3, 16'd4));
    push_i <= 1'b0;
    drain_offsets();

    // inverted clamp at the extremes
    set_config('1, '0, 16'h7FFF);
    push_beat(ranges('0, 16'hFFFE, '1, 16'd1234));
    push_beat(ranges('1, '0, 16'd1234, '1));
    push_i <= 1'b0;
    drain_offsets();

    // spare index must not touch any register
    cfg_write(CFG_IDX_SPARE, '0);
    set_config('0, '1, '0);
    push_beat(ranges('0, '1, '1, '0));
    push_beat(ranges(16'h1234, 16'hFEDC, 16'h0001, 16'h8000));
    push_i <= 1'b0;
    drain_offsets();
    set_config('0, '1, 16'd1);
    push_beat(ranges('0, '1, '1, '0));
    push_beat(ranges('1, '0, '0, '1));
    push_i <= 1'b0;
    drain_offsets();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0, 1: begin tx_idle_pct = 25; rx_idle_pct = 50; end
        2, 3: begin tx_idle_pct = 50; rx_idle_pct = 25; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      a = CFG_DATA_W'($urandom);
      b = CFG_DATA_W'($urandom);
      case (ph)
        0: set_config(MIN_DIST_RST, MAX_DIST_RST, CFG_DATA_W'(GOAL_DIST_RST));
        1: set_config((a < b) ? a : b, (a < b) ? b : a, CFG_DATA_W'($urandom));
        2: set_config((a < b) ? b : a, (a < b) ? a : b, CFG_DATA_W'($urandom));
        3: set_config((a < b) ? a : b, (a < b) ? b : a,
                      CFG_DATA_W'($urandom_range(2000, 0)));
        4: set_config(MIN_DIST_RST, MAX_DIST_RST, CFG_DATA_W'(GOAL_DIST_RST));
        default: set_config(a, b, CFG_DATA_W'($urandom));
      endcase
      // stall the result side while items keep coming so full_o must rise
      if (ph == 4) hold_req <= 1'b1;
      repeat (PHASE_BEATS)
        push_beat(ranges(pick_range(), pick_range(), pick_range(), pick_range()));
      push_i <= 1'b0;
      drain_offsets();
    end

    repeat (20) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("range_sensor_diff_filter_core regression: pass");
    else
      $display("range_sensor_diff_filter_core regression: fail");
    $finish;
  end
endmodule
